>>> sv/fxf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxf_pkg
// Shared types and constants for the fixed-point to IEEE-754 converter.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------

package fxf_pkg;

    // Field widths of the transfers
    localparam int INT_W      = 31;
    localparam int FRAC_IN_W  = 32;
    localparam int SGL_W      = 32;
    localparam int DBL_W      = 64;

    // IEEE-754 format constants
    localparam int SGL_BIAS   = 127;
    localparam int DBL_BIAS   = 1023;
    localparam int SGL_MANT   = 23;
    localparam int DBL_MANT   = 52;
    localparam int SGL_EXP_W  = 8;
    localparam int DBL_EXP_W  = 11;

    // Leading-one search works on groups of this many bits
    localparam int GRP_W      = 8;
    localparam int GRP_POS_W  = 3;

    typedef struct packed {
        logic                 negative;
        logic [INT_W-1:0]     integer_magnitude;
        logic [FRAC_IN_W-1:0] fraction_bits;
    } in_t;

    typedef struct packed {
        logic [SGL_W-1:0] single_pattern;
        logic [DBL_W-1:0] double_pattern;
    } out_t;

    // Position of the highest set bit within one group (zero when empty)
    function automatic logic [GRP_POS_W-1:0] grp_msb(input logic [GRP_W-1:0] v);
        logic [GRP_POS_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < GRP_W; i++) begin
            if (v[i]) begin
                pos = GRP_POS_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

>>> sv/fxf_lead.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxf_lead
// Two-stage leading-one detector: per-group search, then group select.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------

module fxf_lead #(
    parameter int MAG_W = 63,
    parameter int POS_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_neg,
    input  logic [MAG_W-1:0] in_mag,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_neg,
    output logic [MAG_W-1:0] out_mag,
    output logic [POS_W-1:0] out_pos,
    output logic             out_zero
);

    localparam int GRP_W     = fxf_pkg::GRP_W;
    localparam int GRP_POS_W = fxf_pkg::GRP_POS_W;
    localparam int NG        = (MAG_W + GRP_W - 1) / GRP_W;
    localparam int PAD_W     = NG * GRP_W;

    logic                          s1_vld_reg;
    logic                          s1_neg_reg;
    logic [MAG_W-1:0]              s1_mag_reg;
    logic [NG-1:0]                 s1_nz_reg;
    logic [NG-1:0][GRP_POS_W-1:0]  s1_pos_reg;
    logic [NG-1:0]                 s1_nz_next;
    logic [NG-1:0][GRP_POS_W-1:0]  s1_pos_next;

    logic                          s2_vld_reg;
    logic                          s2_neg_reg;
    logic [MAG_W-1:0]              s2_mag_reg;
    logic [POS_W-1:0]              s2_pos_reg;
    logic                          s2_zero_reg;
    logic [POS_W-1:0]              s2_pos_next;

    logic                          s1_rdy;
    logic                          s2_rdy;
    logic [PAD_W-1:0]              mag_pad;

    // Advance a stage when it is empty or its content moves on
    assign s2_rdy   = !s2_vld_reg || out_ready;
    assign s1_rdy   = !s1_vld_reg || s2_rdy;
    assign in_ready = s1_rdy;

    // Group flags and positions within each group
    assign mag_pad = PAD_W'(in_mag);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            s1_nz_next[g]  = |mag_pad[g*GRP_W +: GRP_W];
            s1_pos_next[g] = fxf_pkg::grp_msb(mag_pad[g*GRP_W +: GRP_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (s1_rdy) begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_rdy && in_valid) begin
            s1_neg_reg <= in_neg;
            s1_mag_reg <= in_mag;
            s1_nz_reg  <= s1_nz_next;
            s1_pos_reg <= s1_pos_next;
        end
    end

    // Pick the highest non-empty group
    always_comb begin
        s2_pos_next = '0;
        for (int g = 0; g < NG; g++) begin
            if (s1_nz_reg[g]) begin
                s2_pos_next = POS_W'(g * GRP_W) + POS_W'(s1_pos_reg[g]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (s2_rdy) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_rdy && s1_vld_reg) begin
            s2_neg_reg  <= s1_neg_reg;
            s2_mag_reg  <= s1_mag_reg;
            s2_pos_reg  <= s2_pos_next;
            s2_zero_reg <= ~|s1_nz_reg;
        end
    end

    assign out_valid = s2_vld_reg;
    assign out_neg   = s2_neg_reg;
    assign out_mag   = s2_mag_reg;
    assign out_pos   = s2_pos_reg;
    assign out_zero  = s2_zero_reg;

endmodule

>>> sv/fxf_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxf_norm
// Normalising shift and biased exponents for both formats.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------

module fxf_norm #(
    parameter int MAG_W  = 63,
    parameter int POS_W  = 6,
    parameter int FRAC_W = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_neg,
    input  logic [MAG_W-1:0]               in_mag,
    input  logic [POS_W-1:0]               in_pos,
    input  logic                           in_zero,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_neg,
    output logic                           out_zero,
    output logic [fxf_pkg::SGL_EXP_W-1:0]  out_sexp,
    output logic [fxf_pkg::DBL_EXP_W-1:0]  out_dexp,
    output logic [fxf_pkg::DBL_MANT-1:0]   out_mant
);

    localparam int MANT_W  = fxf_pkg::DBL_MANT;
    localparam int XW      = MAG_W + MANT_W;
    localparam int SGL_OFF = fxf_pkg::SGL_BIAS - FRAC_W;
    localparam int DBL_OFF = fxf_pkg::DBL_BIAS - FRAC_W;

    logic                           vld_reg;
    logic                           neg_reg;
    logic                           zero_reg;
    logic [fxf_pkg::SGL_EXP_W-1:0]  sexp_reg;
    logic [fxf_pkg::DBL_EXP_W-1:0]  dexp_reg;
    logic [MANT_W-1:0]              mant_reg;
    logic [fxf_pkg::SGL_EXP_W-1:0]  sexp_next;
    logic [fxf_pkg::DBL_EXP_W-1:0]  dexp_next;
    logic [MANT_W-1:0]              mant_next;

    logic [POS_W-1:0]               shift_amt;
    logic [XW-1:0]                  shifted;

    assign in_ready = !vld_reg || out_ready;

    // Bring the leading one to the top and keep the bits just below it
    assign shift_amt = POS_W'(MAG_W - 1) - in_pos;
    assign shifted   = {in_mag, {MANT_W{1'b0}}} << shift_amt;
    assign mant_next = shifted[XW-2 -: MANT_W];

    // Exponent is the leading-one position less the fraction width, plus bias
    assign sexp_next = fxf_pkg::SGL_EXP_W'(SGL_OFF) + fxf_pkg::SGL_EXP_W'(in_pos);
    assign dexp_next = fxf_pkg::DBL_EXP_W'(DBL_OFF) + fxf_pkg::DBL_EXP_W'(in_pos);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            neg_reg  <= in_neg;
            zero_reg <= in_zero;
            sexp_reg <= sexp_next;
            dexp_reg <= dexp_next;
            mant_reg <= mant_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_neg   = neg_reg;
    assign out_zero  = zero_reg;
    assign out_sexp  = sexp_reg;
    assign out_dexp  = dexp_reg;
    assign out_mant  = mant_reg;

endmodule

>>> sv/fxf_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxf_pack
// Output stage: assembles both bit patterns and holds the result transfer.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------

module fxf_pack (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_neg,
    input  logic                           in_zero,
    input  logic [fxf_pkg::SGL_EXP_W-1:0]  in_sexp,
    input  logic [fxf_pkg::DBL_EXP_W-1:0]  in_dexp,
    input  logic [fxf_pkg::DBL_MANT-1:0]   in_mant,
    output logic                           out_valid,
    input  logic                           out_ready,
    output fxf_pkg::out_t                  out_data
);

    logic           vld_reg;
    fxf_pkg::out_t  data_reg;
    fxf_pkg::out_t  data_next;

    assign in_ready = !vld_reg || out_ready;

    // Zero magnitude gives all-zero patterns, sign dropped
    always_comb begin
        if (in_zero) begin
            data_next = '0;
        end else begin
            data_next.single_pattern = {in_neg, in_sexp,
                in_mant[fxf_pkg::DBL_MANT-1 -: fxf_pkg::SGL_MANT]};
            data_next.double_pattern = {in_neg, in_dexp, in_mant};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

>>> sv/fixed_to_ieee754_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_to_ieee754_converter
// Sign-magnitude fixed point to IEEE-754 single and double, truncating.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry the fixed-point value (sign flag, 31-bit
//   integer magnitude, fraction of FRAC_WIDTH bits, MSB worth one half).
//   m_valid/m_ready/m_data carry one result per input: the single and the
//   double bit patterns side by side. A zero magnitude gives all zeros.
//   Each input transfer passes four registered stages in order: group-wise
//   leading-one search, group select, normalising shift, pattern assembly.
//   Throughput is one transfer per cycle; every stage is a register with its
//   own valid bit, so a new value is taken each cycle while results flow.
//   When m_ready is low the stages fill up and s_ready drops once all four
//   hold a value; nothing is lost or repeated. Reset (aresetn low, sampled
//   on aclk) empties the pipeline; there is no other state.
//   FRAC_WIDTH may range from 1 to 52; fraction bits at or above it are
//   ignored and bits above bit 31 read as zero.
// ----------------------------------------------------------------------------

module fixed_to_ieee754_converter #(
    parameter int FRAC_WIDTH = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  fxf_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output fxf_pkg::out_t  m_data
);

    // Width outside 1..52 is held at the nearest end
    localparam int FRAC_W = (FRAC_WIDTH < 1) ? 1 : ((FRAC_WIDTH > 52) ? 52 : FRAC_WIDTH);
    localparam int MAG_W  = fxf_pkg::INT_W + FRAC_W;
    localparam int NG     = (MAG_W + fxf_pkg::GRP_W - 1) / fxf_pkg::GRP_W;
    localparam int POS_W  = $clog2(NG * fxf_pkg::GRP_W);

    logic [FRAC_W-1:0]              frac;
    logic [MAG_W-1:0]               mag;

    logic                           ld_valid;
    logic                           ld_ready;
    logic                           ld_neg;
    logic [MAG_W-1:0]               ld_mag;
    logic [POS_W-1:0]               ld_pos;
    logic                           ld_zero;

    logic                           nm_valid;
    logic                           nm_ready;
    logic                           nm_neg;
    logic                           nm_zero;
    logic [fxf_pkg::SGL_EXP_W-1:0]  nm_sexp;
    logic [fxf_pkg::DBL_EXP_W-1:0]  nm_dexp;
    logic [fxf_pkg::DBL_MANT-1:0]   nm_mant;

    // Keep fraction bits below the width; those beyond the field read as zero
    for (genvar i = 0; i < FRAC_W; i++) begin : g_frac
        if (i < fxf_pkg::FRAC_IN_W) begin : g_bit
            assign frac[i] = s_data.fraction_bits[i];
        end else begin : g_pad
            assign frac[i] = 1'b0;
        end
    end

    assign mag = {s_data.integer_magnitude, frac};

    fxf_lead #(
        .MAG_W (MAG_W),
        .POS_W (POS_W)
    ) u_lead (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_neg    (s_data.negative),
        .in_mag    (mag),
        .out_valid (ld_valid),
        .out_ready (ld_ready),
        .out_neg   (ld_neg),
        .out_mag   (ld_mag),
        .out_pos   (ld_pos),
        .out_zero  (ld_zero)
    );

    fxf_norm #(
        .MAG_W  (MAG_W),
        .POS_W  (POS_W),
        .FRAC_W (FRAC_W)
    ) u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ld_valid),
        .in_ready  (ld_ready),
        .in_neg    (ld_neg),
        .in_mag    (ld_mag),
        .in_pos    (ld_pos),
        .in_zero   (ld_zero),
        .out_valid (nm_valid),
        .out_ready (nm_ready),
        .out_neg   (nm_neg),
        .out_zero  (nm_zero),
        .out_sexp  (nm_sexp),
        .out_dexp  (nm_dexp),
        .out_mant  (nm_mant)
    );

    fxf_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (nm_valid),
        .in_ready  (nm_ready),
        .in_neg    (nm_neg),
        .in_zero   (nm_zero),
        .in_sexp   (nm_sexp),
        .in_dexp   (nm_dexp),
        .in_mant   (nm_mant),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // Input stalls only when the whole pipeline is full and the output waits
    a_stall_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled with room in the pipeline");

    // Both patterns carry the same sign
    a_sign_match : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.single_pattern[31] == m_data.double_pattern[63]))
        else $error("sign differs between single and double");

    // Single mantissa is the truncated double mantissa
    a_mant_trunc : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.single_pattern[22:0] == m_data.double_pattern[51:29]))
        else $error("single mantissa is not a truncation of double");

    // Unbiased exponents agree, or both patterns are zero
    a_exp_match : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.double_pattern == 64'd0 && m_data.single_pattern == 32'd0)
            || (11'(m_data.single_pattern[30:23]) + 11'd896
                == m_data.double_pattern[62:52])))
        else $error("exponents of single and double disagree");

endmodule

>>> bench/fxf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxf_checker
// Watches both channels of the converter and checks each result it returns.
// ----------------------------------------------------------------------------
// Every accepted input transfer is turned into the single and double bit
// patterns that the converter should return, and queued in order. Every
// accepted output transfer is compared field by field with the oldest queued
// patterns. The failure count, the number of results still awaited and the
// number of results checked are handed to the testbench top.
// ----------------------------------------------------------------------------

module fxf_checker #(
    parameter int FRAC_WIDTH = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_ready,
    input  fxf_pkg::in_t   s_data,
    input  logic           m_valid,
    input  logic           m_ready,
    input  fxf_pkg::out_t  m_data,
    output int             fail_count,
    output int             awaited_count,
    output int             checked_count
);

    localparam int REPORT_MAX = 10;

    fxf_pkg::out_t awaited_patterns[$];

    // Position of the highest set bit; -1 for an all-zero word
    function automatic int leading_one(input logic [63:0] w);
        int pos;
        pos = -1;
        for (int i = 0; i < 64; i++) begin
            if (w[i]) begin
                pos = i;
            end
        end
        return pos;
    endfunction

    // Work out both truncated IEEE-754 patterns for one fixed-point value
    function automatic fxf_pkg::out_t ieee_patterns(input fxf_pkg::in_t v);
        int            fw;
        int            p;
        int            e;
        logic [63:0]   ip;
        logic [63:0]   fp;
        logic [63:0]   below;
        logic [63:0]   falign;
        logic [63:0]   tail;
        logic [7:0]    se;
        logic [10:0]   de;
        fxf_pkg::out_t r;
        fw = FRAC_WIDTH;
        if (fw < 1) begin
            fw = 1;
        end
        if (fw > 52) begin
            fw = 52;
        end
        ip   = 64'(v.integer_magnitude);
        fp   = 64'(v.fraction_bits) & ((64'd1 << fw) - 64'd1);
        tail = '0;
        r    = '0;
        e    = 0;
        if (ip != 0 || fp != 0) begin
            if (ip != 0) begin
                // leading one in the integer part; fraction follows below it
                p      = leading_one(ip);
                below  = ip & ((64'd1 << p) - 64'd1);
                falign = fp << (64 - fw);
                if (p > 0) begin
                    tail = (below << (64 - p)) | (falign >> p);
                end else begin
                    tail = falign;
                end
                e = p;
            end else begin
                // value below one: normalise on the fraction alone
                p     = leading_one(fp);
                below = fp & ((64'd1 << p) - 64'd1);
                if (p > 0) begin
                    tail = below << (64 - p);
                end
                e = p - fw;
            end
            se = 8'(e + fxf_pkg::SGL_BIAS);
            de = 11'(e + fxf_pkg::DBL_BIAS);
            r.single_pattern = {v.negative, se, tail[63 -: fxf_pkg::SGL_MANT]};
            r.double_pattern = {v.negative, de, tail[63 -: fxf_pkg::DBL_MANT]};
        end
        return r;
    endfunction

    // Record each input transfer and check each output transfer
    always @(posedge aclk) begin
        fxf_pkg::out_t want;
        if (!aresetn) begin
            awaited_patterns.delete();
            fail_count    <= 0;
            checked_count <= 0;
            awaited_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_patterns.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < REPORT_MAX) begin
                        $display("[%0t] unexpected result: single %h double %h",
                                 $realtime, m_data.single_pattern, m_data.double_pattern);
                    end
                end else begin
                    want = awaited_patterns.pop_front();
                    checked_count <= checked_count + 1;
                    if (m_data.single_pattern !== want.single_pattern ||
                        m_data.double_pattern !== want.double_pattern) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < REPORT_MAX) begin
                            $display({"[%0t] mismatch: single exp %h got %h, ",
                                      "double exp %h got %h"},
                                     $realtime, want.single_pattern, m_data.single_pattern,
                                     want.double_pattern, m_data.double_pattern);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                awaited_patterns.push_back(ieee_patterns(s_data));
            end
            awaited_count <= awaited_patterns.size();
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench top for the fixed-point to IEEE-754 converter.
// ----------------------------------------------------------------------------
// Drives a directed set of edge values (zero, negative zero, extremes of
// both magnitude fields, single set bits, long mantissas) and then random
// values shaped to place the leading one anywhere in the integer or the
// fraction part. Both sides idle in random bursts except in the final part.
// Checking is done by fxf_checker; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb;

    localparam int FRAC_WIDTH   = 32;
    localparam int RANDOM_ITEMS = 1930;
    localparam int QUIET_TAIL   = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;

    logic           aclk;
    logic           aresetn;
    logic           s_valid;
    logic           s_ready;
    fxf_pkg::in_t   s_data;
    logic           m_valid;
    logic           m_ready;
    fxf_pkg::out_t  m_data;

    int    fail_count;
    int    awaited_count;
    int    checked_count;
    int    cycle_count;
    int    sent_count;
    int    below_one_count;
    int    zero_count;
    logic  quiet;

    fixed_to_ieee754_converter #(
        .FRAC_WIDTH (FRAC_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    fxf_checker #(
        .FRAC_WIDTH (FRAC_WIDTH)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .awaited_count (awaited_count),
        .checked_count (checked_count)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: end the run if it overruns the cycle limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still awaited",
                 cycle_count, awaited_count);
        $display("Verification failed");
        $finish;
    end

    // Receiver: stall in random bursts, with long ready stretches between
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
            m_ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(50, 200)) @(negedge aclk);
            end else begin
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
    end

    // Hold one value on the input channel until it is transferred
    task automatic send_value(input fxf_pkg::in_t v);
        s_data  <= v;
        s_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
        sent_count++;
        if (v.integer_magnitude == '0) begin
            if (v.fraction_bits == '0) begin
                zero_count++;
            end else begin
                below_one_count++;
            end
        end
    endtask

    // Drop valid for a random burst, unless idling is switched off
    task automatic maybe_idle(input logic allow);
        if (allow && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
    endtask

    function automatic fxf_pkg::in_t make_value(input logic neg, input logic [30:0] im,
                                                input logic [31:0] fr);
        fxf_pkg::in_t v;
        v.negative          = neg;
        v.integer_magnitude = im;
        v.fraction_bits     = fr;
        return v;
    endfunction

    // Random value with the leading one placed anywhere
    function automatic fxf_pkg::in_t random_value();
        fxf_pkg::in_t v;
        logic [31:0]  ri;
        logic [31:0]  rf;
        ri = $urandom();
        rf = $urandom();
        v.negative = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                // integer part of random length, full fraction
                v.integer_magnitude = 31'(ri >> $urandom_range(1, 31));
                v.fraction_bits     = rf;
            end
            3, 4, 5: begin
                // value below one, leading one at a random fraction position
                v.integer_magnitude = '0;
                v.fraction_bits     = rf >> $urandom_range(0, 31);
            end
            6: begin
                // single set bits in either field
                v.integer_magnitude = ($urandom_range(0, 1) != 0) ?
                                      31'(1) << $urandom_range(0, 30) : '0;
                v.fraction_bits     = 32'(1) << $urandom_range(0, 31);
            end
            7: begin
                v.integer_magnitude = '0;
                v.fraction_bits     = '0;
            end
            default: begin
                v.integer_magnitude = 31'(ri);
                v.fraction_bits     = rf;
            end
        endcase
        return v;
    endfunction

    // Stimulus and verdict
    initial begin
        fxf_pkg::in_t directed[$];
        logic allow;
        s_valid         = 1'b0;
        s_data          = '0;
        quiet           = 1'b0;
        sent_count      = 0;
        below_one_count = 0;
        zero_count      = 0;
        aresetn         = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // zero with either sign, and the extremes of both fields
        directed.push_back(make_value(1'b0, 31'h0, 32'h0));
        directed.push_back(make_value(1'b1, 31'h0, 32'h0));
        directed.push_back(make_value(1'b0, 31'h7FFFFFFF, 32'hFFFFFFFF));
        directed.push_back(make_value(1'b1, 31'h7FFFFFFF, 32'hFFFFFFFF));
        directed.push_back(make_value(1'b0, 31'h7FFFFFFF, 32'h0));
        directed.push_back(make_value(1'b1, 31'h40000000, 32'h0));
        directed.push_back(make_value(1'b0, 31'h1, 32'h0));
        directed.push_back(make_value(1'b1, 31'h1, 32'hFFFFFFFF));
        directed.push_back(make_value(1'b0, 31'h1, 32'h80000000));
        // values below one: largest and smallest fractions
        directed.push_back(make_value(1'b0, 31'h0, 32'h80000000));
        directed.push_back(make_value(1'b1, 31'h0, 32'h00000001));
        directed.push_back(make_value(1'b0, 31'h0, 32'hFFFFFFFF));
        directed.push_back(make_value(1'b1, 31'h0, 32'h00000003));
        directed.push_back(make_value(1'b0, 31'h0, 32'h00FFFFFF));
        // long mantissas that lose bits in the single or the double format
        directed.push_back(make_value(1'b0, 31'h00FFFFFF, 32'hFFFFFFFF));
        directed.push_back(make_value(1'b1, 31'h00800001, 32'h00000001));
        directed.push_back(make_value(1'b0, 31'h00000003, 32'hAAAAAAAB));
        directed.push_back(make_value(1'b1, 31'h55555555, 32'h55555555));
        directed.push_back(make_value(1'b0, 31'h2AAAAAAA, 32'hAAAAAAAA));
        directed.push_back(make_value(1'b1, 31'h00001000, 32'h00000800));

        foreach (directed[i]) begin
            send_value(directed[i]);
            maybe_idle(1'b1);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_TAIL) begin
                quiet = 1'b1;
            end
            // leave some stretches without sender gaps
            allow = !quiet && ((i % 400) < 300);
            send_value(random_value());
            maybe_idle(allow);
        end
        s_valid <= 1'b0;

        // drain the pipeline
        while (awaited_count != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Converted %0d values (%0d below one, %0d zero), %0d results checked",
                 sent_count, below_one_count, zero_count, checked_count);
        if (fail_count == 0 && awaited_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Failures: %0d", fail_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
